@@ rtl/glc_pkg.sv @@
// Shared types and constants for the group label compaction block.
// Depends on nothing; used by rtl/group_label_compaction.sv.
`timescale 1ns / 1ps

package glc_pkg;

    localparam int IDX_W = 10;   // entry_index width
    localparam int LAB_W = 11;   // label width
    localparam int GRP_W = 12;   // signed group register width

    // Request kinds carried on s_tuser
    localparam logic [1:0] REQ_WRITE   = 2'd0;
    localparam logic [1:0] REQ_COMPACT = 2'd1;
    localparam logic [1:0] REQ_READ    = 2'd2;

    // Configuration register indexes
    localparam logic [0:0] CFG_CURRENT = 1'b0;
    localparam logic [0:0] CFG_MARKER  = 1'b1;

    // Group code meaning "no group"
    localparam logic signed [GRP_W-1:0] GROUP_NONE = -12'sd1;

    // Largest label value a stored field can hold
    localparam int LAB_CODE_MAX = (1 << LAB_W) - 1;

    typedef struct packed {
        logic             used;
        logic [LAB_W-1:0] label;
    } entry_t;

endpackage

@@ rtl/group_label_compaction.sv @@
// Group label compaction: entry table, label presence/remap stores and walk sequencer.
// Depends on glc_pkg (rtl/glc_pkg.sv).
`timescale 1ns / 1ps
// Flow: an accepted write or read beat goes straight to the final state, which loads the
// result register once it is free and then returns to idle, where the next beat is taken.
// A compaction runs from acceptance to the result register as one table walk to find the
// largest used label and mark presence, one walk over labels 0..max to renumber (skipped
// when no entry is used), one table walk to rewrite labels, then the final state; all
// driven by a single entry-table port pair.
// Throughput: one item at a time; s_tready is high only while the sequencer is idle, and a
// stalled result holds the sequencer in its final state.
// Reset: synchronous active-low; afterwards a clearing pass over max(ENTRIES, labels+1)
// addresses zeroes the entry table and the presence store before the first beat is taken.

module group_label_compaction #(
    parameter int ENTRIES = 1024,
    parameter int LABELS  = 1024
) (
    input  logic        aclk,
    input  logic        aresetn,
    // s_tdata: entry_index[9:0], entry_used[10], entry_label[21:11], zero pad [23:22]
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [23:0] s_tdata,
    // s_tuser: req_type[1:0]
    input  logic [1:0]  s_tuser,
    // m_tdata: read_label[10:0], read_used[11], removed_count[22:12],
    //          new_current[34:23], new_marker[46:35], zero pad [47]
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [47:0] m_tdata,
    // configuration write port
    input  logic        cfg_we,
    input  logic [0:0]  cfg_index,
    input  logic [11:0] cfg_wdata
);

    localparam int LAB_W  = glc_pkg::LAB_W;
    localparam int GRP_W  = glc_pkg::GRP_W;
    // labels that can actually be stored (saturation limit)
    localparam int LMAX   = (LABELS > glc_pkg::LAB_CODE_MAX) ? glc_pkg::LAB_CODE_MAX : LABELS;
    localparam int LDEPTH = LMAX + 1;
    localparam int LAW    = $clog2(LDEPTH);
    localparam int EAW    = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
    localparam int NMAX   = (ENTRIES > LDEPTH) ? ENTRIES : LDEPTH;
    localparam int CW     = $clog2(NMAX + 1);
    localparam int NW     = LAW + 1;

    typedef enum logic [2:0] {
        ST_CLR,
        ST_IDLE,
        ST_SCAN,
        ST_RENUM,
        ST_APPLY,
        ST_FIN
    } state_t;

    // ------------------------------------------------------------------
    // Storage
    // ------------------------------------------------------------------
    glc_pkg::entry_t  ent_mem [ENTRIES];
    logic             prs_mem [LDEPTH];
    logic [LAB_W-1:0] rmp_mem [LDEPTH];

    glc_pkg::entry_t  e_rd_reg;
    logic             p_rd_reg;
    logic [LAB_W-1:0] r_rd_reg;

    // ------------------------------------------------------------------
    // Control registers
    // ------------------------------------------------------------------
    state_t                  state_reg;
    logic [CW-1:0]           cnt_reg;
    logic [1:0]              req_reg;
    logic                    idx_ok_reg;
    logic [LAB_W-1:0]        res_lab_reg;
    logic                    res_used_reg;
    logic signed [GRP_W-1:0] cur_reg;
    logic signed [GRP_W-1:0] mrk_reg;
    logic signed [GRP_W-1:0] newcur_reg;
    logic signed [GRP_W-1:0] newmrk_reg;
    logic                    resel_reg;
    logic                    any_used_reg;
    logic [LAB_W-1:0]        max_reg;
    logic [NW-1:0]           n_reg;
    logic [LAB_W-1:0]        removed_reg;
    logic                    p1_vld_reg;
    logic [LAW-1:0]          p1_lab_reg;
    logic                    a1_vld_reg;
    logic [EAW-1:0]          a1_idx_reg;
    logic                    a2_vld_reg;
    logic [EAW-1:0]          a2_idx_reg;
    logic                    a2_used_reg;
    logic                    m_valid_reg;
    logic [LAB_W-1:0]        m_lab_reg;
    logic                    m_used_reg;
    logic [LAB_W-1:0]        m_removed_reg;
    logic signed [GRP_W-1:0] m_cur_reg;
    logic signed [GRP_W-1:0] m_mrk_reg;

    // ------------------------------------------------------------------
    // Input decode
    // ------------------------------------------------------------------
    logic [glc_pkg::IDX_W-1:0] in_idx;
    logic                      in_used;
    logic [LAB_W-1:0]          in_lab;
    logic [LAB_W-1:0]          in_lab_sat;
    logic [31:0]               in_idx32;
    logic                      in_ok;
    logic [EAW-1:0]            in_addr;
    logic                      s_acc;

    assign in_idx     = s_tdata[9:0];
    assign in_used    = s_tdata[10];
    assign in_lab     = s_tdata[21:11];
    assign in_lab_sat = (in_lab > LAB_W'(LMAX)) ? LAB_W'(LMAX) : in_lab;
    assign in_idx32   = 32'(in_idx);
    assign in_ok      = in_idx32 < 32'(ENTRIES);
    assign in_addr    = in_idx32[EAW-1:0];

    assign s_tready = (state_reg == ST_IDLE);
    assign s_acc    = s_tvalid && s_tready;

    // ------------------------------------------------------------------
    // Walk counter views
    // ------------------------------------------------------------------
    logic [31:0]    cnt32;
    logic [EAW-1:0] cnt_eaddr;
    logic [LAW-1:0] cnt_laddr;
    logic           ent_more;
    logic           lab_more;
    logic           clr_last;

    assign cnt32     = 32'(cnt_reg);
    assign cnt_eaddr = cnt32[EAW-1:0];
    assign cnt_laddr = cnt32[LAW-1:0];
    assign ent_more  = cnt32 < 32'(ENTRIES);
    assign lab_more  = cnt32 <= 32'(max_reg);
    assign clr_last  = cnt32 == 32'(NMAX - 1);

    // Settle the current group once renumbering is over: an emptied or
    // unset current takes the survivor count and re-selects unused entries.
    logic signed [GRP_W-1:0] fix_cur;
    logic                    fix_resel;
    logic                    cur_none;

    assign cur_none  = (newcur_reg == glc_pkg::GROUP_NONE);
    assign fix_cur   = cur_none ? GRP_W'(n_reg) : newcur_reg;
    assign fix_resel = resel_reg || cur_none;

    logic cur_hit;
    logic mrk_hit;

    assign cur_hit = (cur_reg == {1'b0, LAB_W'(p1_lab_reg)});
    assign mrk_hit = (mrk_reg == {1'b0, LAB_W'(p1_lab_reg)});

    logic out_free;
    assign out_free = !m_valid_reg || m_tready;

    // ------------------------------------------------------------------
    // Memory port steering
    // ------------------------------------------------------------------
    logic            e_we, e_re;
    logic [EAW-1:0]  e_waddr, e_raddr;
    glc_pkg::entry_t e_wdata;
    logic            p_we, p_re, p_wdata;
    logic [LAW-1:0]  p_waddr, p_raddr;
    logic            r_we, r_re;
    logic [LAW-1:0]  r_waddr, r_raddr;
    logic [LAB_W-1:0] r_wdata;

    always_comb begin
        e_we    = 1'b0;
        e_re    = 1'b0;
        e_waddr = cnt_eaddr;
        e_raddr = cnt_eaddr;
        e_wdata = '0;
        p_we    = 1'b0;
        p_re    = 1'b0;
        p_waddr = cnt_laddr;
        p_raddr = cnt_laddr;
        p_wdata = 1'b0;
        r_we    = 1'b0;
        r_re    = 1'b0;
        r_waddr = p1_lab_reg;
        r_raddr = e_rd_reg.label[LAW-1:0];
        r_wdata = LAB_W'(n_reg);
        unique case (state_reg)
            ST_CLR: begin
                // zero both tables across the longer of the two depths
                e_we = ent_more;
                p_we = cnt32 < 32'(LDEPTH);
            end
            ST_IDLE: begin
                e_waddr       = in_addr;
                e_raddr       = in_addr;
                e_wdata.used  = in_used;
                e_wdata.label = in_lab_sat;
                e_we = s_acc && (s_tuser == glc_pkg::REQ_WRITE) && in_ok;
                e_re = s_acc && (s_tuser == glc_pkg::REQ_READ) && in_ok;
            end
            ST_SCAN: begin
                e_re    = ent_more;
                p_waddr = e_rd_reg.label[LAW-1:0];
                p_wdata = 1'b1;
                p_we    = p1_vld_reg && e_rd_reg.used;
            end
            ST_RENUM: begin
                p_re    = lab_more;
                // drop each presence mark as it is consumed
                p_waddr = p1_lab_reg;
                p_we    = p1_vld_reg;
                r_we    = p1_vld_reg;
            end
            ST_APPLY: begin
                e_re          = ent_more;
                r_re          = a1_vld_reg && e_rd_reg.used;
                e_waddr       = a2_idx_reg;
                e_wdata.used  = a2_used_reg;
                e_wdata.label = a2_used_reg ? r_rd_reg : newcur_reg[LAB_W-1:0];
                e_we          = a2_vld_reg && (a2_used_reg || resel_reg);
            end
            ST_FIN: begin
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (e_we) begin
            ent_mem[e_waddr] <= e_wdata;
        end
        if (e_re) begin
            e_rd_reg <= ent_mem[e_raddr];
        end
    end

    always_ff @(posedge aclk) begin
        if (p_we) begin
            prs_mem[p_waddr] <= p_wdata;
        end
        if (p_re) begin
            p_rd_reg <= prs_mem[p_raddr];
        end
    end

    always_ff @(posedge aclk) begin
        if (r_we) begin
            rmp_mem[r_waddr] <= r_wdata;
        end
        if (r_re) begin
            r_rd_reg <= rmp_mem[r_raddr];
        end
    end

    // ------------------------------------------------------------------
    // Sequencer
    // ------------------------------------------------------------------
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_CLR;
            cnt_reg     <= '0;
            cur_reg     <= '0;
            mrk_reg     <= glc_pkg::GROUP_NONE;
            m_valid_reg <= 1'b0;
            p1_vld_reg  <= 1'b0;
            a1_vld_reg  <= 1'b0;
            a2_vld_reg  <= 1'b0;
        end else begin
            if (cfg_we) begin
                unique case (cfg_index)
                    glc_pkg::CFG_CURRENT: cur_reg <= cfg_wdata;
                    glc_pkg::CFG_MARKER:  mrk_reg <= cfg_wdata;
                    default: begin
                    end
                endcase
            end
            // the final state reloads the result register itself
            if (m_valid_reg && m_tready && (state_reg != ST_FIN)) begin
                m_valid_reg <= 1'b0;
            end

            unique case (state_reg)
                ST_CLR: begin
                    cnt_reg <= cnt_reg + 1'b1;
                    if (clr_last) begin
                        state_reg <= ST_IDLE;
                    end
                end

                ST_IDLE: begin
                    if (s_acc) begin
                        req_reg      <= s_tuser;
                        idx_ok_reg   <= in_ok;
                        res_lab_reg  <= in_ok ? in_lab_sat : '0;
                        res_used_reg <= in_ok && in_used;
                        cnt_reg      <= '0;
                        newcur_reg   <= cur_reg;
                        newmrk_reg   <= mrk_reg;
                        resel_reg    <= 1'b0;
                        any_used_reg <= 1'b0;
                        max_reg      <= '0;
                        n_reg        <= '0;
                        removed_reg  <= '0;
                        p1_vld_reg   <= 1'b0;
                        a1_vld_reg   <= 1'b0;
                        a2_vld_reg   <= 1'b0;
                        state_reg    <= (s_tuser == glc_pkg::REQ_COMPACT) ? ST_SCAN : ST_FIN;
                    end
                end

                ST_SCAN: begin
                    // walk the table: find the largest used label, mark presence
                    if (ent_more) begin
                        cnt_reg <= cnt_reg + 1'b1;
                    end
                    p1_vld_reg <= ent_more;
                    if (p1_vld_reg && e_rd_reg.used) begin
                        any_used_reg <= 1'b1;
                        if (!any_used_reg || (e_rd_reg.label > max_reg)) begin
                            max_reg <= e_rd_reg.label;
                        end
                    end
                    if (!ent_more && !p1_vld_reg) begin
                        cnt_reg <= '0;
                        if (any_used_reg) begin
                            state_reg <= ST_RENUM;
                        end else begin
                            newcur_reg <= fix_cur;
                            resel_reg  <= fix_resel;
                            state_reg  <= ST_APPLY;
                        end
                    end
                end

                ST_RENUM: begin
                    // walk labels 0..max: assign dense numbers, track the registers
                    if (lab_more) begin
                        cnt_reg <= cnt_reg + 1'b1;
                    end
                    p1_vld_reg <= lab_more;
                    p1_lab_reg <= cnt_laddr;
                    if (p1_vld_reg) begin
                        if (p_rd_reg) begin
                            if (cur_hit) begin
                                newcur_reg <= GRP_W'(n_reg);
                                resel_reg  <= 1'b1;
                            end
                            if (mrk_hit) begin
                                newmrk_reg <= GRP_W'(n_reg);
                            end
                            n_reg <= n_reg + 1'b1;
                        end else begin
                            if (cur_hit) begin
                                newcur_reg <= glc_pkg::GROUP_NONE;
                            end
                            if (mrk_hit) begin
                                newmrk_reg <= glc_pkg::GROUP_NONE;
                            end
                            removed_reg <= removed_reg + 1'b1;
                        end
                    end
                    if (!lab_more && !p1_vld_reg) begin
                        cnt_reg    <= '0;
                        newcur_reg <= fix_cur;
                        resel_reg  <= fix_resel;
                        state_reg  <= ST_APPLY;
                    end
                end

                ST_APPLY: begin
                    // three-step walk: read entry, look up remap, write back
                    if (ent_more) begin
                        cnt_reg <= cnt_reg + 1'b1;
                    end
                    a1_vld_reg  <= ent_more;
                    a1_idx_reg  <= cnt_eaddr;
                    a2_vld_reg  <= a1_vld_reg;
                    a2_idx_reg  <= a1_idx_reg;
                    a2_used_reg <= e_rd_reg.used;
                    if (!ent_more && !a1_vld_reg && !a2_vld_reg) begin
                        cur_reg   <= newcur_reg;
                        mrk_reg   <= newmrk_reg;
                        state_reg <= ST_FIN;
                    end
                end

                ST_FIN: begin
                    // hold until the result register is free, then load it
                    if (out_free) begin
                        m_valid_reg <= 1'b1;
                        m_cur_reg   <= cur_reg;
                        m_mrk_reg   <= mrk_reg;
                        unique case (req_reg)
                            glc_pkg::REQ_WRITE: begin
                                m_lab_reg     <= res_lab_reg;
                                m_used_reg    <= res_used_reg;
                                m_removed_reg <= '0;
                            end
                            glc_pkg::REQ_COMPACT: begin
                                m_lab_reg     <= '0;
                                m_used_reg    <= 1'b0;
                                m_removed_reg <= removed_reg;
                            end
                            glc_pkg::REQ_READ: begin
                                m_lab_reg     <= idx_ok_reg ? e_rd_reg.label : '0;
                                m_used_reg    <= idx_ok_reg && e_rd_reg.used;
                                m_removed_reg <= '0;
                            end
                            default: begin
                                m_lab_reg     <= '0;
                                m_used_reg    <= 1'b0;
                                m_removed_reg <= '0;
                            end
                        endcase
                        state_reg <= ST_IDLE;
                    end
                end

                default: begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {1'b0, m_mrk_reg, m_cur_reg, m_removed_reg, m_used_reg, m_lab_reg};

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------
    // A compact beat starts the table walk on the next cycle.
    a_compact_starts: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_acc && (s_tuser == glc_pkg::REQ_COMPACT)) |=> (state_reg == ST_SCAN))
        else $error("compaction did not start its table walk");

    // Survivors plus removed labels cover exactly 0..max.
    a_label_balance: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_APPLY && any_used_reg) |->
        (32'(n_reg) + 32'(removed_reg) == 32'(max_reg) + 32'd1))
        else $error("renumbering count mismatch");

    // Write-back never lands on the entry being fetched.
    a_apply_no_collide: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_APPLY && e_we && e_re) |-> (e_waddr != e_raddr))
        else $error("apply walk read/write collision");

    // Remap lookups stay inside the renumbered range.
    a_remap_in_range: assert property (@(posedge aclk) disable iff (!aresetn)
        r_re |-> (any_used_reg && (32'(r_raddr) <= 32'(max_reg))))
        else $error("remap lookup outside renumbered labels");

    // No result is loaded while a walk is still running.
    a_no_early_result: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_SCAN || state_reg == ST_RENUM || state_reg == ST_APPLY)
        |=> !$rose(m_valid_reg))
        else $error("result produced during compaction walk");

endmodule

@@ bench/tb_group_label_compaction.sv @@
// Self-checking bench for group_label_compaction: directed and random entry
// writes, reads and label compactions checked against an in-bench predictor.
// Depends on glc_pkg (rtl/glc_pkg.sv) and rtl/group_label_compaction.sv.
`timescale 1ns / 1ps

module tb_group_label_compaction;

    localparam int ENTRIES = 1024;
    localparam int LABELS  = 1024;

    localparam int IDX_W = glc_pkg::IDX_W;
    localparam int LAB_W = glc_pkg::LAB_W;
    localparam int GRP_W = glc_pkg::GRP_W;

    // Request code the block must ignore
    localparam logic [1:0] REQ_UNKNOWN = 2'd3;

    // No beat for this many cycles means the block is hung. The limit leaves
    // ample margin over a compaction with a full label range, the clearing pass
    // after reset and a long result stall.
    localparam int HANG_LIMIT = 20000;

    // One result beat, laid out as m_tdata[46:0]: label in the low bits
    typedef struct packed {
        logic [GRP_W-1:0] marker;
        logic [GRP_W-1:0] current;
        logic [LAB_W-1:0] removed;
        logic             used;
        logic [LAB_W-1:0] label;
    } outcome_t;

    logic        aclk;
    logic        aresetn   = 1'b0;
    logic        s_tvalid  = 1'b0;
    logic        s_tready;
    logic [23:0] s_tdata   = '0;
    logic [1:0]  s_tuser   = '0;
    logic        m_tvalid;
    logic        m_tready  = 1'b0;
    logic [47:0] m_tdata;
    logic        cfg_we    = 1'b0;
    logic [0:0]  cfg_index = '0;
    logic [11:0] cfg_wdata = '0;

    group_label_compaction #(
        .ENTRIES (ENTRIES),
        .LABELS  (LABELS)
    ) u_dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata)
    );

    // Predicted block state: entry table and the two group registers
    logic                    tbl_used  [ENTRIES];
    logic [LAB_W-1:0]        tbl_label [ENTRIES];
    logic signed [GRP_W-1:0] sel_current = 12'sd0;
    logic signed [GRP_W-1:0] sel_marker  = glc_pkg::GROUP_NONE;

    outcome_t expected_outcomes[$];
    int       error_count = 0;
    int       idle_cycles = 0;
    bit       no_gaps     = 1'b0;   // hold both sides busy when set

    initial begin
        aclk = 1'b0;
        forever #10 aclk = ~aclk;
    end

    initial begin
        for (int i = 0; i < ENTRIES; i++) begin
            tbl_used[i]  = 1'b0;
            tbl_label[i] = '0;
        end
    end

    //------------------------------------------------------------------
    // Predictor
    //------------------------------------------------------------------

    // Renumber the labels in use densely, move the group registers along
    // and return how many labels in 0..max were empty.
    function automatic logic [LAB_W-1:0] renumber_groups();
        bit               present   [LABELS+1];
        logic [LAB_W-1:0] new_label [LABELS+1];
        int top, survivors, removed;
        int cur, mrk, next_cur, next_mrk;
        bit reassign;
        top       = -1;
        survivors = 0;
        removed   = 0;
        cur       = sel_current;
        mrk       = sel_marker;
        next_cur  = cur;
        next_mrk  = mrk;
        reassign  = 1'b0;
        for (int l = 0; l <= LABELS; l++) begin
            present[l]   = 1'b0;
            new_label[l] = '0;
        end
        for (int i = 0; i < ENTRIES; i++) begin
            if (tbl_used[i]) begin
                present[tbl_label[i]] = 1'b1;
                if (int'(tbl_label[i]) > top) top = int'(tbl_label[i]);
            end
        end
        for (int l = 0; l <= top; l++) begin
            new_label[l] = LAB_W'(survivors);
            if (present[l]) begin
                if (cur == l) begin
                    next_cur = survivors;
                    reassign = 1'b1;
                end
                if (mrk == l) next_mrk = survivors;
                survivors++;
            end else begin
                // an emptied group loses its selection
                if (cur == l) next_cur = -1;
                if (mrk == l) next_mrk = -1;
                removed++;
            end
        end
        // no current group left: select a fresh one past the survivors
        if (next_cur == -1) begin
            next_cur = survivors;
            reassign = 1'b1;
        end
        for (int i = 0; i < ENTRIES; i++) begin
            if (tbl_used[i])
                tbl_label[i] = new_label[tbl_label[i]];
            else if (reassign)
                tbl_label[i] = LAB_W'(next_cur);
        end
        sel_current = GRP_W'(next_cur);
        sel_marker  = GRP_W'(next_mrk);
        return LAB_W'(removed);
    endfunction

    // Apply one accepted request to the predicted state; return its result
    function automatic outcome_t apply_request(input logic [1:0] req,
                                               input logic [IDX_W-1:0] idx,
                                               input logic used,
                                               input logic [LAB_W-1:0] label);
        outcome_t         o;
        logic [LAB_W-1:0] stored;
        o = '0;
        case (req)
            glc_pkg::REQ_WRITE: begin
                // labels past the top code saturate
                stored         = (label > LABELS) ? LAB_W'(LABELS) : label;
                tbl_used[idx]  = used;
                tbl_label[idx] = stored;
                o.label        = stored;
                o.used         = used;
            end
            glc_pkg::REQ_COMPACT: begin
                o.removed = renumber_groups();
            end
            glc_pkg::REQ_READ: begin
                o.label = tbl_label[idx];
                o.used  = tbl_used[idx];
            end
            default: ;
        endcase
        o.current = sel_current;
        o.marker  = sel_marker;
        return o;
    endfunction

    //------------------------------------------------------------------
    // Driving and checking
    //------------------------------------------------------------------

    // Mostly back-to-back, sometimes a short gap, rarely a long one
    function automatic int pick_gap();
        int r;
        if (no_gaps) return 0;
        r = $urandom_range(0, 99);
        if (r < 60) return 0;
        if (r < 90) return $urandom_range(1, 3);
        if (r < 98) return $urandom_range(4, 15);
        return $urandom_range(20, 80);
    endfunction

    task automatic report_mismatch(input string what, input logic [11:0] got,
                                   input logic [11:0] want);
        error_count++;
        $display("[%0t] mismatch on %s: got 0x%03h, expected 0x%03h",
                 $realtime, what, got, want);
    endtask

    // Drive one request beat, hold it until taken, then log its prediction
    task automatic send_item(input logic [1:0] req, input logic [IDX_W-1:0] idx,
                             input logic used, input logic [LAB_W-1:0] label);
        int gap;
        gap = pick_gap();
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= req;
        s_tdata  <= {2'b00, label, used, idx};
        @(posedge aclk);
        while (s_tready !== 1'b1) @(posedge aclk);
        expected_outcomes.push_back(apply_request(req, idx, used, label));
    endtask

    // Drop valid and wait until every pending result has come back
    task automatic drain();
        s_tvalid <= 1'b0;
        while (expected_outcomes.size() != 0) @(posedge aclk);
        repeat (4) @(posedge aclk);
    endtask

    // Write both group registers; call only with the block idle
    task automatic set_groups(input logic signed [GRP_W-1:0] cur,
                              input logic signed [GRP_W-1:0] mrk);
        cfg_we    <= 1'b1;
        cfg_index <= glc_pkg::CFG_CURRENT;
        cfg_wdata <= cur;
        @(posedge aclk);
        cfg_index <= glc_pkg::CFG_MARKER;
        cfg_wdata <= mrk;
        @(posedge aclk);
        cfg_we      <= 1'b0;
        sel_current  = cur;
        sel_marker   = mrk;
    endtask

    // Result side: stall at random unless told to stay ready
    initial begin
        int stall;
        forever begin
            stall = pick_gap();
            if (stall > 0) begin
                m_tready <= 1'b0;
                repeat (stall) @(posedge aclk);
            end
            m_tready <= 1'b1;
            repeat ($urandom_range(1, 12)) @(posedge aclk);
        end
    end

    // Compare each result beat with the oldest prediction, field by field
    always @(posedge aclk) begin
        outcome_t seen;
        outcome_t want;
        if (aresetn && m_tvalid === 1'b1 && m_tready) begin
            seen = outcome_t'(m_tdata[46:0]);
            if (expected_outcomes.size() == 0) begin
                report_mismatch("result beat with nothing pending", seen.label, '0);
            end else begin
                want = expected_outcomes.pop_front();
                if (seen.label !== want.label)
                    report_mismatch("read_label", seen.label, want.label);
                if (seen.used !== want.used)
                    report_mismatch("read_used", seen.used, want.used);
                if (seen.removed !== want.removed)
                    report_mismatch("removed_count", seen.removed, want.removed);
                if (seen.current !== want.current)
                    report_mismatch("new_current", seen.current, want.current);
                if (seen.marker !== want.marker)
                    report_mismatch("new_marker", seen.marker, want.marker);
            end
        end
    end

    // Hang detector: count cycles in which no beat moves on either side
    always @(posedge aclk) begin
        if ((s_tvalid && s_tready === 1'b1) || (m_tvalid === 1'b1 && m_tready) || cfg_we)
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= HANG_LIMIT) begin
            $display("Simulation FAILED");
            $finish;
        end
    end

    //------------------------------------------------------------------
    // Tests
    //------------------------------------------------------------------

    // Reset contents, compaction of an empty table with no current group,
    // and a request code the block must ignore.
    task automatic test_empty_table();
        set_groups(glc_pkg::GROUP_NONE, 12'sd1024);
        send_item(glc_pkg::REQ_READ, 10'd0, 1'b0, 11'd0);
        send_item(glc_pkg::REQ_READ, 10'd1023, 1'b1, 11'd2047);
        send_item(glc_pkg::REQ_COMPACT, 10'd0, 1'b0, 11'd0);
        send_item(REQ_UNKNOWN, 10'h3FF, 1'b1, 11'h7FF);
        drain();
    endtask

    // Label saturation, table corners, a wide label range with large gaps
    task automatic test_extremes();
        send_item(glc_pkg::REQ_WRITE, 10'd0, 1'b1, 11'd2047);
        send_item(glc_pkg::REQ_WRITE, 10'd1023, 1'b1, 11'd0);
        send_item(glc_pkg::REQ_WRITE, 10'd5, 1'b1, 11'd3);
        send_item(glc_pkg::REQ_WRITE, 10'd6, 1'b0, 11'd1025);
        send_item(glc_pkg::REQ_WRITE, 10'd7, 1'b1, 11'd1023);
        send_item(glc_pkg::REQ_READ, 10'd6, 1'b0, 11'd0);
        send_item(glc_pkg::REQ_COMPACT, 10'd0, 1'b0, 11'd0);
        send_item(glc_pkg::REQ_READ, 10'd0, 1'b0, 11'd0);
        send_item(glc_pkg::REQ_READ, 10'd6, 1'b0, 11'd0);
        send_item(glc_pkg::REQ_READ, 10'd7, 1'b0, 11'd0);
        drain();
    endtask

    // Group registers on empty labels, outside the range, and on live labels
    task automatic test_group_tracking();
        send_item(glc_pkg::REQ_WRITE, 10'd10, 1'b1, 11'd9);
        send_item(glc_pkg::REQ_WRITE, 10'd11, 1'b1, 11'd12);
        drain();
        // both point at empty labels: current moves past survivors, marker drops
        set_groups(12'sd6, 12'sd7);
        send_item(glc_pkg::REQ_COMPACT, 10'd0, 1'b0, 11'd0);
        send_item(glc_pkg::REQ_READ, 10'd6, 1'b0, 11'd0);
        send_item(glc_pkg::REQ_READ, 10'd11, 1'b0, 11'd0);
        drain();
        // both outside 0..max: nothing follows, unused entries keep labels
        set_groups(12'sd1024, glc_pkg::GROUP_NONE);
        send_item(glc_pkg::REQ_COMPACT, 10'd0, 1'b0, 11'd0);
        send_item(glc_pkg::REQ_READ, 10'd6, 1'b0, 11'd0);
        drain();
        // both on live labels
        set_groups(12'sd2, 12'sd0);
        send_item(glc_pkg::REQ_COMPACT, 10'd0, 1'b0, 11'd0);
        send_item(glc_pkg::REQ_READ, 10'd6, 1'b0, 11'd0);
        drain();
    endtask

    // Register values aimed at the corners and at the small live labels
    function automatic logic signed [GRP_W-1:0] pick_group();
        int r;
        r = $urandom_range(0, 99);
        if (r < 15) return glc_pkg::GROUP_NONE;
        if (r < 25) return 12'sd1024;
        if (r < 35) return 12'sd0;
        if (r < 85) return GRP_W'($urandom_range(0, 20));
        return GRP_W'($urandom_range(0, LABELS));
    endfunction

    // One random request: most traffic hits a small window of entries with
    // small labels so compactions see dense, overlapping groups.
    task automatic random_request(input int window_base);
        int               r;
        logic [1:0]       req;
        logic [IDX_W-1:0] idx;
        logic             used;
        logic [LAB_W-1:0] label;
        r = $urandom_range(0, 99);
        if (r < 54)      req = glc_pkg::REQ_WRITE;
        else if (r < 90) req = glc_pkg::REQ_READ;
        else if (r < 96) req = glc_pkg::REQ_COMPACT;
        else             req = REQ_UNKNOWN;
        if ($urandom_range(0, 9) < 7)
            idx = IDX_W'(window_base + $urandom_range(0, 31));
        else
            idx = IDX_W'($urandom_range(0, ENTRIES - 1));
        used = ($urandom_range(0, 4) != 0);
        r = $urandom_range(0, 99);
        if (r < 75)      label = LAB_W'($urandom_range(0, 15));
        else if (r < 90) label = LAB_W'($urandom_range(0, LABELS));
        else             label = LAB_W'($urandom_range(0, 2047));
        send_item(req, idx, used, label);
    endtask

    // Random traffic in phases, each with fresh group registers
    task automatic test_random_traffic();
        int base;
        for (int phase = 0; phase < 8; phase++) begin
            set_groups(pick_group(), pick_group());
            no_gaps = (phase % 4 == 3);
            base    = $urandom_range(0, ENTRIES - 32);
            repeat (225) random_request(base);
            drain();
        end
        no_gaps = 1'b0;
    endtask

    initial begin
        repeat (10) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        test_empty_table();
        test_extremes();
        test_group_tracking();
        test_random_traffic();

        // catch any stray beat after the last expected one
        drain();
        repeat (50) @(posedge aclk);
        if (error_count == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule
